// ===== design/rrs_pkg.sv =====
// Shared types and constants for the range reversal store.
// Used by the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package rrs_pkg;

  localparam int MaxGenes = 4096;
  localparam int AddrW    = $clog2(MaxGenes);
  localparam int PosW     = 13;
  localparam int LabelW   = 13;
  localparam int KindW    = 2;
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;

  // Item kinds
  localparam logic [KindW-1:0] KindInit    = 2'd0;
  localparam logic [KindW-1:0] KindReverse = 2'd1;
  localparam logic [KindW-1:0] KindQuery   = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic RegGeneCount = 1'b0;

  localparam logic [PosW-1:0] GeneCountReset = PosW'(MaxGenes);

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  first_pos;
    logic [PosW-1:0]  last_pos;
  } in_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic              bad_position;
  } out_t;

endpackage

// ===== design/range_reversal_store.sv =====
// Range reversal store: ordering of labels kept in one dual-read memory.
// Depends on rrs_pkg for the payload structs, item kinds and sizes.
`timescale 1ns / 1ps
//
//  channel   direction  signals                                   payload
//  -------   ---------  ----------------------------------------  -----------------
//  in        sink       in_valid_i, in_stall_o, in_data_i         rrs_pkg::in_t
//  out       source     out_valid_o, out_stall_i, out_data_o      rrs_pkg::out_t
//  config    APB slave  psel, penable, pwrite, paddr, pwdata, ... gene_count at 0x0
//
//  A query reads the store, then loads the result register; an out-of-range
//  position loads the error result directly. In a reversal the single write
//  port moves one entry per cycle, while both entries of the next pair are read
//  at once. An initialize item writes all 4096 entries, one entry per cycle,
//  after the accepting cycle.
//  The store holds no defined contents after reset until the first initialize.
//  A result waiting under out_stall_i blocks only a new query beat.

module range_reversal_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rrs_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rrs_pkg::out_t                 out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrs_pkg::PaddrW-1:0]    paddr,
  input  logic [rrs_pkg::PdataW-1:0]    pwdata,
  output logic [rrs_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);
  import rrs_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StInit  = 2'd1;
  localparam logic [1:0] StRev   = 2'd2;
  localparam logic [1:0] StQuery = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PosW-1:0]   gene_count_q;
  logic [PosW-1:0]   eff_count;
  logic [AddrW-1:0]  lo_q, lo_d, hi_q, hi_d, lo_n, hi_n;
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic              ph_q, ph_d;
  logic              out_valid_q;
  out_t              out_data_q;
  logic              out_load;
  out_t              out_new;

  logic [LabelW-1:0] mem [MaxGenes];
  logic [LabelW-1:0] rd_a_q, rd_b_q;
  logic              we, re;
  logic [AddrW-1:0]  wa, ra_a, ra_b;
  logic [LabelW-1:0] wd;

  logic              accept;
  logic [PosW-1:0]   first_m1, last_m1;
  logic              q_bad, rev_go;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegGeneCount) ? PdataW'(gene_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gene_count_q <= GeneCountReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegGeneCount) begin
      gene_count_q <= pwdata[PosW-1:0];
    end
  end

  assign eff_count = (gene_count_q > PosW'(MaxGenes)) ? PosW'(MaxGenes) : gene_count_q;

  // Input decode
  assign in_stall_o = (state_q != StIdle) ||
                      (in_data_i.kind == KindQuery && out_valid_q && out_stall_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign first_m1 = in_data_i.first_pos - PosW'(1);
  assign last_m1  = in_data_i.last_pos - PosW'(1);
  assign q_bad    = (in_data_i.first_pos == '0) || (in_data_i.first_pos > eff_count);
  // Spans of one position or out of range change nothing
  assign rev_go   = (in_data_i.first_pos != '0) &&
                    (in_data_i.last_pos > in_data_i.first_pos) &&
                    (in_data_i.last_pos <= eff_count);

  assign lo_n = lo_q + AddrW'(1);
  assign hi_n = hi_q - AddrW'(1);

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    cnt_d    = cnt_q;
    ph_d     = ph_q;
    we       = 1'b0;
    wa       = cnt_q;
    wd       = LabelW'(cnt_q) + LabelW'(1);
    re       = 1'b0;
    ra_a     = first_m1[AddrW-1:0];
    ra_b     = last_m1[AddrW-1:0];
    out_load = 1'b0;
    out_new.label        = rd_a_q;
    out_new.bad_position = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          case (in_data_i.kind)
            KindInit: begin
              cnt_d   = '0;
              state_d = StInit;
            end
            KindReverse: begin
              if (rev_go) begin
                re      = 1'b1;
                lo_d    = first_m1[AddrW-1:0];
                hi_d    = last_m1[AddrW-1:0];
                ph_d    = 1'b0;
                state_d = StRev;
              end
            end
            KindQuery: begin
              if (q_bad) begin
                out_load             = 1'b1;
                out_new.label        = '0;
                out_new.bad_position = 1'b1;
              end else begin
                re      = 1'b1;
                state_d = StQuery;
              end
            end
            default: begin
              // drop unused kind
            end
          endcase
        end
      end
      StInit: begin
        we    = 1'b1;
        cnt_d = cnt_q + AddrW'(1);
        if (cnt_q == AddrW'(MaxGenes - 1)) begin
          state_d = StIdle;
        end
      end
      StRev: begin
        we = 1'b1;
        if (!ph_q) begin
          wa   = lo_q;
          wd   = rd_b_q;
          ph_d = 1'b1;
        end else begin
          wa   = hi_q;
          wd   = rd_a_q;
          ph_d = 1'b0;
          // fetch the next pair while the high entry is written
          if (lo_n < hi_n) begin
            re   = 1'b1;
            ra_a = lo_n;
            ra_b = hi_n;
            lo_d = lo_n;
            hi_d = hi_n;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StQuery: begin
        out_load = 1'b1;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    cnt_q <= cnt_d;
    if (out_load) begin
      out_data_q <= out_new;
    end
  end

  // Order store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_a_q <= mem[ra_a];
      rd_b_q <= mem[ra_b];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/rrs_checker.sv =====
// Port-level checker for the range reversal store, bound to the top level.
// Depends on rrs_pkg for the payload structs and item kinds.
`timescale 1ns / 1ps

module rrs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input rrs_pkg::in_t               in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input rrs_pkg::out_t              out_data_o,
  input logic                       pready
);
  import rrs_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // an error result carries no label
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_position |-> out_data_o.label == '0)
    else $error("bad position result with nonzero label");

  // a query at position zero answers with an error on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.kind == KindQuery && in_data_i.first_pos == '0
    |=> out_valid_o && out_data_o.bad_position)
    else $error("zero position query not flagged");

  // an initialize beat keeps the input stalled while the store is rewritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.kind == KindInit |=> in_stall_o)
    else $error("input taken during initialize");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind range_reversal_store rrs_checker u_rrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

// ===== tb/range_reversal_store_test.sv =====
// Self-checking testbench for the range reversal store: directed table, then random phases.
// Depends on rrs_pkg and range_reversal_store; a local predictor tracks the label order.
`timescale 1ns / 1ps

module range_reversal_store_test;
  import rrs_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;

  localparam int DrainCycles = 4200;     // longest busy stretch: initialize or full reversal
  localparam int HoldCycles  = 400;
  localparam int LimitCycles = 10_000_000;
  localparam int NumPhases   = 7;
  localparam int NumDirected = 24;

  localparam logic [PosW-1:0] PhaseCount [NumPhases] =
    '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd300, 13'd17, 13'd4096};
  localparam int PhaseItems [NumPhases] = '{60, 20, 15, 45, 55, 35, 32};

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [PosW-1:0]   first_pos;
    logic [PosW-1:0]   last_pos;
    logic              pinned;
    logic [LabelW-1:0] want_label;
    logic              want_bad;
  } step_row_t;

  localparam step_row_t DirectedSteps [NumDirected] = '{
    '{KindInit,    13'd0,    13'd0,    1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd1,    13'd0,    1'b1, 13'd1,    1'b0},
    '{KindQuery,   13'd4096, 13'd0,    1'b1, 13'd4096, 1'b0},
    '{KindQuery,   13'd0,    13'd8191, 1'b1, 13'd0,    1'b1},
    '{KindQuery,   13'd4097, 13'd0,    1'b1, 13'd0,    1'b1},
    '{KindQuery,   13'd8191, 13'd8191, 1'b1, 13'd0,    1'b1},
    '{KindReverse, 13'd1,    13'd4096, 1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd1,    13'd0,    1'b1, 13'd4096, 1'b0},
    '{KindQuery,   13'd4096, 13'd0,    1'b1, 13'd1,    1'b0},
    '{KindReverse, 13'd5,    13'd3,    1'b0, 13'd0,    1'b0},
    '{KindReverse, 13'd0,    13'd10,   1'b0, 13'd0,    1'b0},
    '{KindReverse, 13'd10,   13'd4097, 1'b0, 13'd0,    1'b0},
    '{KindReverse, 13'd2,    13'd8191, 1'b0, 13'd0,    1'b0},
    '{KindReverse, 13'd7,    13'd7,    1'b0, 13'd0,    1'b0},
    '{KindReverse, 13'd1,    13'd2,    1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd1,    13'd0,    1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd2,    13'd0,    1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd7,    13'd0,    1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd5,    13'd0,    1'b0, 13'd0,    1'b0},
    '{KindUnused,  13'd8191, 13'd8191, 1'b0, 13'd0,    1'b0},
    '{KindReverse, 13'd100,  13'd200,  1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd150,  13'd0,    1'b0, 13'd0,    1'b0},
    '{KindInit,    13'd8191, 13'd8191, 1'b0, 13'd0,    1'b0},
    '{KindQuery,   13'd2048, 13'd0,    1'b1, 13'd2048, 1'b0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_t               in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_t              out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  range_reversal_store u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predictor state: label order and the gene count the block holds
  logic [LabelW-1:0] order_q [MaxGenes];
  logic [PosW-1:0]   count_q = GeneCountReset;
  out_t              pending_labels [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_en = 1'b1;
  logic        sink_idle_en = 1'b1;
  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  out_t        want;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int active_count();
    return (count_q > MaxGenes) ? MaxGenes : int'(count_q);
  endfunction

  function automatic void store_step(input in_t beat, output bit yields, output out_t lbl);
    int eff, lo, hi;
    logic [LabelW-1:0] t;
    eff = active_count();
    yields = 1'b0;
    lbl = '0;
    case (beat.kind)
      KindInit: begin
        for (int i = 0; i < MaxGenes; i++) order_q[i] = LabelW'(i + 1);
      end
      KindReverse: begin
        if (beat.first_pos != 0 && beat.last_pos >= beat.first_pos && beat.last_pos <= eff) begin
          lo = int'(beat.first_pos) - 1;
          hi = int'(beat.last_pos) - 1;
          while (lo < hi) begin
            t = order_q[lo];
            order_q[lo] = order_q[hi];
            order_q[hi] = t;
            lo++;
            hi--;
          end
        end
      end
      KindQuery: begin
        yields = 1'b1;
        if (beat.first_pos == 0 || beat.first_pos > eff) lbl.bad_position = 1'b1;
        else lbl.label = order_q[beat.first_pos - 1];
      end
      default: ;
    endcase
  endfunction

  // Mostly well-formed spans and in-range queries; the rest is broken spans,
  // bad positions, unused kinds and the odd initialize.
  function automatic in_t pick_beat(input bit query_only);
    in_t b;
    int eff, roll, span;
    eff = active_count();
    roll = query_only ? 60 : int'($urandom_range(99));
    b.kind = KindQuery;
    b.first_pos = PosW'($urandom);
    b.last_pos = PosW'($urandom);
    if (roll < 3) begin
      b.kind = KindInit;
    end else if (roll < 45) begin
      b.kind = KindReverse;
      if (eff > 0) begin
        b.first_pos = PosW'($urandom_range(eff, 1));
        if ($urandom_range(19) == 0) span = $urandom_range(eff - int'(b.first_pos));
        else span = $urandom_range(15);
        b.last_pos = PosW'((int'(b.first_pos) + span > eff) ? eff : int'(b.first_pos) + span);
      end
    end else if (roll < 53) begin
      b.kind = KindReverse;
      case ($urandom_range(2))
        0: begin
          b.first_pos = PosW'($urandom_range(8191, 2));
          b.last_pos = PosW'($urandom_range(int'(b.first_pos) - 1, 1));
        end
        1: b.first_pos = '0;
        default: begin
          b.last_pos = PosW'($urandom_range(8191, eff + 1));
          b.first_pos = PosW'($urandom_range(int'(b.last_pos), 1));
        end
      endcase
    end else if (roll < 92) begin
      if (eff > 0) b.first_pos = PosW'($urandom_range(eff, 1));
    end else if (roll < 98) begin
      b.first_pos = $urandom_range(1) ? '0 : PosW'($urandom_range(8191, eff + 1));
    end else begin
      b.kind = KindUnused;
    end
    return b;
  endfunction

  task automatic send_beat(input in_t beat, input logic pinned, input out_t pinned_label);
    bit yields;
    out_t lbl;
    while (src_idle_en && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (in_stall_o);
    store_step(beat, yields, lbl);
    if (yields) pending_labels.push_back(pinned ? pinned_label : lbl);
  endtask

  task automatic write_gene_count(input logic [PosW-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_labels.size() != 0);
    // an initialize or a long reversal may still be running
    repeat (DrainCycles) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegGeneCount, 2'b00};
    pwdata <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    count_q = value;
  endtask

  // Result side: random stall, long hold-off on request, in-order check
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_labels.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, expected none, got label %0d bad %0b",
                 $time, out_data_o.label, out_data_o.bad_position);
      end else begin
        want = pending_labels.pop_front();
        if (out_data_o.label !== want.label) begin
          mismatches++;
          $display("%0t: label expected %0d, got %0d", $time, want.label, out_data_o.label);
        end
        if (out_data_o.bad_position !== want.bad_position) begin
          mismatches++;
          $display("%0t: bad_position expected %0b, got %0b",
                   $time, want.bad_position, out_data_o.bad_position);
        end
      end
    end
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= sink_idle_en && ($urandom_range(99) < 38);
    end
  end

  initial begin : sequencer
    in_t       beat;
    step_row_t row;
    int        n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedSteps[i];
      beat = '{kind: row.kind, first_pos: row.first_pos, last_pos: row.last_pos};
      send_beat(beat, row.pinned, '{label: row.want_label, bad_position: row.want_bad});
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) write_gene_count(PhaseCount[ph]);
      src_idle_en = (ph != 3);
      sink_idle_en <= (ph != 3);
      // hold the result side while queries keep coming, so the input backs up
      if (ph == 4) hold_tog <= ~hold_tog;
      n = 0;
      while (n < PhaseItems[ph]) begin
        beat = pick_beat(ph == 4 && n < 12);
        send_beat(beat, 1'b0, '0);
        if (beat.kind != KindUnused) n++;
        if (ph == 5 && n == 20 && beat.kind != KindUnused) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_labels.size() != 0);
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_labels.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== range_reversal_store.f =====
design/rrs_pkg.sv
design/range_reversal_store.sv
design/rrs_checker.sv
tb/range_reversal_store_test.sv
